// ===== rtl/dsf_pkg.sv =====
// dsf_pkg: shared types and constants of the depth speckle filter
// item structs for both channels, register indexes, reset values
// no dependencies
package dsf_pkg;

	localparam int DEPTH_BITS = 16;
	localparam int FRAME_DIM_BITS = 12;
	localparam int MIN_SIM_BITS = 4;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	// smallest frame the window logic supports
	localparam int MIN_WIDTH = 3;
	localparam int MIN_HEIGHT = 2;

	// register reset values
	localparam int FRAME_WIDTH_RST = 640;
	localparam int FRAME_HEIGHT_RST = 480;
	localparam logic [DEPTH_BITS-1:0] NO_DEPTH_RST = 16'd0;
	localparam logic [DEPTH_BITS-1:0] SIMILAR_THR_RST = 16'd200;
	localparam logic [MIN_SIM_BITS-1:0] MIN_SIMILAR_RST = 4'd2;

	// result queue depth, covers the pipeline latency at full rate
	localparam int RES_FIFO_DEPTH = 8;

	typedef logic [DEPTH_BITS-1:0] depth_t;

	typedef enum logic {
		FUNC_PIXEL = 1'b0,
		FUNC_DRAIN = 1'b1
	} func_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_NO_DEPTH     = 3'd2,
		REG_SIMILAR_THR  = 3'd3,
		REG_MIN_SIMILAR  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		func_t  func;
		depth_t pixel_depth;
	} px_item_t;

	typedef struct packed {
		depth_t filtered_depth;
		logic   was_removed;
		logic   frame_last;
	} res_item_t;

	// which neighbors of the center are within the threshold
	typedef struct packed {
		logic [2:0] up;
		logic [2:0] dn;
		logic       left;
		logic       right;
	} nbr_sim_t;

	// per-result position info carried down the pipeline
	typedef struct packed {
		logic test;
		logic use_up;
		logic use_dn;
		logic last;
	} res_meta_t;

endpackage

// ===== rtl/dsf_line_buf.sv =====
// dsf_line_buf: one row of delayed depth samples in a synchronous memory
// read-old-data on a shared address, registered read
// depends on dsf_pkg
module dsf_line_buf import dsf_pkg::*; #(
	parameter int DEPTH = 2048,
	parameter int AW = 11
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] addr,
	input  depth_t        wdata,
	output depth_t        rdata
);

	depth_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			rdata <= mem[addr];
			mem[addr] <= wdata;
		end
	end

endmodule

// ===== rtl/dsf_window.sv =====
// dsf_window: 3x3 window shift registers and the eight neighbor compares
// compares are registered in the cycle after the window shift
// depends on dsf_pkg
module dsf_window import dsf_pkg::*; (
	input  logic     clk,
	input  logic     shift,
	input  depth_t   low_in,
	input  depth_t   mid_in,
	input  depth_t   up_in,
	input  depth_t   no_depth,
	input  depth_t   threshold,
	output nbr_sim_t sim_s4,
	output depth_t   center_s4
);

	// index 0 is the newest column
	depth_t low_q [3];
	depth_t mid_q [3];
	depth_t up_q [3];
	nbr_sim_t sim;

	function automatic logic is_similar(depth_t p, depth_t n, depth_t nd, depth_t thr);
		depth_t diff;
		diff = (p >= n) ? (p - n) : (n - p);
		return (n != nd) && (diff <= thr);
	endfunction

	always_ff @(posedge clk) begin
		if (shift) begin
			low_q[0] <= low_in;
			low_q[1] <= low_q[0];
			low_q[2] <= low_q[1];
			mid_q[0] <= mid_in;
			mid_q[1] <= mid_q[0];
			mid_q[2] <= mid_q[1];
			up_q[0] <= up_in;
			up_q[1] <= up_q[0];
			up_q[2] <= up_q[1];
		end
	end

	// center is the middle of the middle row
	always_comb begin
		sim.left  = is_similar(mid_q[1], mid_q[2], no_depth, threshold);
		sim.right = is_similar(mid_q[1], mid_q[0], no_depth, threshold);
		for (int i = 0; i < 3; i++) begin
			sim.up[i] = is_similar(mid_q[1], up_q[i], no_depth, threshold);
			sim.dn[i] = is_similar(mid_q[1], low_q[i], no_depth, threshold);
		end
	end

	always_ff @(posedge clk) begin
		sim_s4 <= sim;
		center_s4 <= mid_q[1];
	end

endmodule

// ===== rtl/dsf_res_fifo.sv =====
// dsf_res_fifo: small result queue between the filter pipeline and the output
// writes are never refused; the producer keeps a credit count
// depends on dsf_pkg
module dsf_res_fifo import dsf_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  res_item_t wr_item,
	output logic      rd_valid,
	input  logic      rd_ready,
	output res_item_t rd_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	res_item_t buf_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic rd_en;

	assign rd_valid = (count_q != '0);
	assign rd_item = buf_q[rd_ptr_q];
	assign rd_en = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNTW'(1);
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

// ===== rtl/depth_speckle_filter.sv =====
// Depth speckle filter. Takes a raster depth frame one pixel per request and
// returns each pixel one row plus one pixel later, replaced by the no-depth
// code when fewer than min_similar of its valid 3x3 neighbors (5 on the top
// and bottom rows; columns 0 and width-1 pass untouched) lie within
// similar_threshold of it. A pixel request or a drain request is taken every
// clock while credits last; the request-to-queue pipeline spans s0 to s4 and an
// eight-entry result queue, guarded by a credit count, lets the input keep
// running while results wait. Two line memories of MAX_WIDTH entries hold the
// previous two rows; they need no clearing pass after reset, and only
// frame_width, frame_height and the first row refill before output resumes.
// Drain requests push out the last row of a frame once it is fully taken in;
// pixels of the next frame push it out just as well. Writing frame_width or
// frame_height restarts the frame position and drops pending pixels.
module depth_speckle_filter import dsf_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      px_valid,
	output logic                      px_ready,
	input  px_item_t                  px_item,
	output logic                      res_valid,
	input  logic                      res_ready,
	output res_item_t                 res_item,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

	// column / pointer index, width value, row index, height value, pending count, credit count
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);
	localparam int CRW = $clog2(RES_FIFO_DEPTH + 1);
	localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
	localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

	// configuration, frame size kept already clamped
	logic [WW-1:0] eff_w_q;
	logic [HW-1:0] eff_h_q;
	depth_t no_depth_q;
	depth_t thr_q;
	logic [MIN_SIM_BITS-1:0] min_sim_q;

	logic [FRAME_DIM_BITS-1:0] cfg_dim;
	logic [WW-1:0] w_clamp;
	logic [HW-1:0] h_clamp;
	logic size_clr;

	// frame position and pending count
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic [CW-1:0] ptr_q;
	logic [PW-1:0] pend_q;
	logic [CRW-1:0] credit_q;

	// request stage
	logic px_acc;
	logic res_acc;
	logic is_drain;
	logic drain_ok;
	logic pend_full;
	logic push_s0;
	logic emit_s0;
	depth_t push_val;
	res_meta_t meta_s0;
	logic in_col_last;
	logic in_row_last;
	logic out_col_last;
	logic out_row_last;
	logic ptr_last;

	// pipeline
	logic push_s1, push_s2;
	logic emit_s1, emit_s2, emit_s3, emit_s4;
	res_meta_t meta_s1, meta_s2, meta_s3, meta_s4;
	depth_t val_s1, low_s2, mid_s2;
	logic [CW-1:0] ptr_s1;
	depth_t mid_rd;
	depth_t up_rd;
	nbr_sim_t sim_s4;
	depth_t center_s4;
	logic [MIN_SIM_BITS-1:0] sim_cnt;
	logic removed_s4;
	res_item_t res_s4;

	assign px_acc = px_valid && px_ready;
	assign res_acc = res_valid && res_ready;

	// ---------------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------------
	assign cfg_dim = cfg_wdata[FRAME_DIM_BITS-1:0];

	always_comb begin
		if (int'(cfg_dim) < MIN_WIDTH) begin
			w_clamp = WW'(MIN_WIDTH);
		end else if (int'(cfg_dim) > MAX_WIDTH) begin
			w_clamp = WW'(MAX_WIDTH);
		end else begin
			w_clamp = WW'(cfg_dim);
		end
		if (int'(cfg_dim) < MIN_HEIGHT) begin
			h_clamp = HW'(MIN_HEIGHT);
		end else if (int'(cfg_dim) > MAX_HEIGHT) begin
			h_clamp = HW'(MAX_HEIGHT);
		end else begin
			h_clamp = HW'(cfg_dim);
		end
	end

	assign size_clr = cfg_we && ((cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH) ||
		(cfg_reg_t'(cfg_index) == REG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WW'(W_RST);
			eff_h_q <= HW'(H_RST);
			no_depth_q <= NO_DEPTH_RST;
			thr_q <= SIMILAR_THR_RST;
			min_sim_q <= MIN_SIMILAR_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH: begin
					eff_w_q <= w_clamp;
				end
				REG_FRAME_HEIGHT: begin
					eff_h_q <= h_clamp;
				end
				REG_NO_DEPTH: begin
					no_depth_q <= cfg_wdata[DEPTH_BITS-1:0];
				end
				REG_SIMILAR_THR: begin
					thr_q <= cfg_wdata[DEPTH_BITS-1:0];
				end
				REG_MIN_SIMILAR: begin
					min_sim_q <= cfg_wdata[MIN_SIM_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// request stage: every push (pixel or accepted drain) shifts the window
	// by one slot; a result leaves once w+1 pixels are pending
	// ---------------------------------------------------------------------
	assign px_ready = (credit_q < CRW'(RES_FIFO_DEPTH));
	assign is_drain = (px_item.func == FUNC_DRAIN);
	// a drain only counts once the whole frame is in and something is pending
	assign drain_ok = (in_row_q == '0) && (in_col_q == '0) && (pend_q != '0);
	assign pend_full = (pend_q >= (PW'(eff_w_q) + PW'(1)));
	assign push_s0 = px_acc && (!is_drain || drain_ok);
	assign emit_s0 = px_acc && (is_drain ? drain_ok : pend_full);
	// drain slots carry the no-depth code, never used as a neighbor
	assign push_val = is_drain ? no_depth_q : px_item.pixel_depth;

	assign in_col_last = (WW'(in_col_q) == (eff_w_q - WW'(1)));
	assign in_row_last = (HW'(in_row_q) == (eff_h_q - HW'(1)));
	assign out_col_last = (WW'(out_col_q) == (eff_w_q - WW'(1)));
	assign out_row_last = (HW'(out_row_q) == (eff_h_q - HW'(1)));
	assign ptr_last = (WW'(ptr_q) == (eff_w_q - WW'(1)));

	// edge columns pass, top row has no upper neighbors, bottom row no lower
	always_comb begin
		meta_s0.test = (out_col_q != '0) && !out_col_last;
		meta_s0.use_up = (out_row_q != '0);
		meta_s0.use_dn = !out_row_last;
		meta_s0.last = out_row_last && out_col_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			ptr_q <= '0;
			pend_q <= '0;
		end else if (size_clr) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			ptr_q <= '0;
			pend_q <= '0;
		end else begin
			if (px_acc && !is_drain) begin
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_last ? '0 : in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (emit_s0) begin
				if (out_col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_last ? '0 : out_row_q + RW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
			// the line pointer wraps at the frame width so each memory delays by one row
			if (push_s0) begin
				ptr_q <= ptr_last ? '0 : ptr_q + CW'(1);
			end
			if (px_acc && !is_drain && !pend_full) begin
				pend_q <= pend_q + PW'(1);
			end else if (px_acc && is_drain && drain_ok) begin
				pend_q <= pend_q - PW'(1);
			end
		end
	end

	// credits cover results in the pipeline and in the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (emit_s0 && !res_acc) begin
			credit_q <= credit_q + CRW'(1);
		end else if (!emit_s0 && res_acc) begin
			credit_q <= credit_q - CRW'(1);
		end
	end

	// ---------------------------------------------------------------------
	// line memories: the middle row is read in the request cycle, the upper
	// row in the cycle after, from what the middle memory returned
	// ---------------------------------------------------------------------
	dsf_line_buf #(
		.DEPTH(MAX_WIDTH),
		.AW(CW)
	) u_lb_mid (
		.clk(clk),
		.en(push_s0),
		.addr(ptr_q),
		.wdata(push_val),
		.rdata(mid_rd)
	);

	dsf_line_buf #(
		.DEPTH(MAX_WIDTH),
		.AW(CW)
	) u_lb_up (
		.clk(clk),
		.en(push_s1),
		.addr(ptr_s1),
		.wdata(mid_rd),
		.rdata(up_rd)
	);

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s1 <= 1'b0;
			push_s2 <= 1'b0;
			emit_s1 <= 1'b0;
			emit_s2 <= 1'b0;
			emit_s3 <= 1'b0;
			emit_s4 <= 1'b0;
		end else begin
			push_s1 <= push_s0;
			push_s2 <= push_s1;
			emit_s1 <= emit_s0;
			emit_s2 <= emit_s1;
			emit_s3 <= emit_s2;
			emit_s4 <= emit_s3;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		val_s1 <= push_val;
		ptr_s1 <= ptr_q;
		meta_s1 <= meta_s0;
		low_s2 <= val_s1;
		mid_s2 <= mid_rd;
		meta_s2 <= meta_s1;
		meta_s3 <= meta_s2;
		meta_s4 <= meta_s3;
	end

	// window shifts in stage 2, compares are registered into stage 4
	dsf_window u_win (
		.clk(clk),
		.shift(push_s2),
		.low_in(low_s2),
		.mid_in(mid_s2),
		.up_in(up_rd),
		.no_depth(no_depth_q),
		.threshold(thr_q),
		.sim_s4(sim_s4),
		.center_s4(center_s4)
	);

	// ---------------------------------------------------------------------
	// decision: count the neighbors that apply to this row
	// ---------------------------------------------------------------------
	always_comb begin
		sim_cnt = MIN_SIM_BITS'($countones({sim_s4.up & {3{meta_s4.use_up}},
			sim_s4.dn & {3{meta_s4.use_dn}}, sim_s4.left, sim_s4.right}));
		// an invalid center passes as it is
		removed_s4 = meta_s4.test && (center_s4 != no_depth_q) && (sim_cnt < min_sim_q);
		res_s4.filtered_depth = removed_s4 ? no_depth_q : center_s4;
		res_s4.was_removed = removed_s4;
		res_s4.frame_last = meta_s4.last;
	end

	dsf_res_fifo #(
		.DEPTH(RES_FIFO_DEPTH)
	) u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(emit_s4),
		.wr_item(res_s4),
		.rd_valid(res_valid),
		.rd_ready(res_ready),
		.rd_item(res_item)
	);

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	// a result on the output always holds a credit
	assert property (@(posedge clk) disable iff (!arst_n) res_valid |-> (credit_q != '0))
		else $error("result shown without a credit");

	// never more than one row plus one pixel pending
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= (PW'(eff_w_q) + PW'(1)))
		else $error("pending count beyond one row plus one");

	// line pointer stays inside the active row
	assert property (@(posedge clk) disable iff (!arst_n) WW'(ptr_q) < eff_w_q)
		else $error("line pointer beyond frame width");

	// an emitting request takes one credit
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit_s0 && !res_acc) |=> (credit_q == ($past(credit_q) + CRW'(1))))
		else $error("credit not taken for an emitted result");

endmodule

// ===== tb/depth_speckle_filter_checker.sv =====
// checker for the depth speckle filter: watches the pixel, result and register ports,
// predicts every filtered pixel and compares it field by field with what comes out
// depends on dsf_pkg
`timescale 1ns / 100ps

module depth_speckle_filter_checker import dsf_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      px_valid,
	input  logic                      px_ready,
	input  px_item_t                  px_item,
	input  logic                      res_valid,
	input  logic                      res_ready,
	input  res_item_t                 res_item,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
	output int                        fail_count,
	output int                        results_due,
	output int                        results_seen
);

	// two rows plus three pixels of history covers the whole window
	localparam int HIST_SLOTS = 2 * MAX_WIDTH + 3;

	depth_t history [HIST_SLOTS];
	int unsigned hist_head;
	int unsigned backlog;
	int unsigned in_row, in_col, out_row, out_col;

	logic [FRAME_DIM_BITS-1:0] width_reg, height_reg;
	depth_t no_depth, threshold;
	logic [MIN_SIM_BITS-1:0] min_similar;

	res_item_t filtered_q [$];

	function automatic int unsigned active_width();
		if (width_reg < MIN_WIDTH) return MIN_WIDTH;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned active_height();
		if (height_reg < MIN_HEIGHT) return MIN_HEIGHT;
		if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
		return height_reg;
	endfunction

	// pixel stored 'back' requests before the newest one
	function automatic depth_t older(int unsigned back);
		return history[(hist_head + HIST_SLOTS - 1 - back) % HIST_SLOTS];
	endfunction

	function automatic void store(depth_t d);
		history[hist_head] = d;
		hist_head = (hist_head + 1) % HIST_SLOTS;
	endfunction

	function automatic int unsigned near_match(depth_t p, depth_t n);
		int unsigned diff;
		if (n == no_depth) return 0;
		diff = (p >= n) ? p - n : n - p;
		return (diff <= threshold) ? 1 : 0;
	endfunction

	// decision for the pixel one row plus one pixel behind the newest
	function automatic res_item_t filter_center();
		int unsigned w, h, c, votes;
		depth_t p;
		res_item_t r;
		w = active_width();
		h = active_height();
		c = w + 1;
		p = older(c);
		r.filtered_depth = p;
		r.was_removed = 1'b0;
		r.frame_last = (out_row == h - 1) && (out_col == w - 1);
		if (out_col != 0 && out_col != w - 1 && p != no_depth) begin
			votes = near_match(p, older(c + 1)) + near_match(p, older(c - 1));
			if (out_row != 0)
				votes += near_match(p, older(c + w + 1)) + near_match(p, older(c + w))
					+ near_match(p, older(c + w - 1));
			if (out_row != h - 1)
				votes += near_match(p, older(c - w + 1)) + near_match(p, older(c - w))
					+ near_match(p, older(c - w - 1));
			if (votes < min_similar) begin
				r.filtered_depth = no_depth;
				r.was_removed = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic void retire_center();
		filtered_q.push_back(filter_center());
		backlog--;
		out_col++;
		if (out_col >= active_width()) begin
			out_col = 0;
			out_row = (out_row + 1 >= active_height()) ? 0 : out_row + 1;
		end
	endfunction

	function automatic void restart_frame();
		backlog = 0;
		in_row = 0;
		in_col = 0;
		out_row = 0;
		out_col = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < HIST_SLOTS; i++) history[i] = '0;
			hist_head = 0;
			width_reg = FRAME_DIM_BITS'(FRAME_WIDTH_RST);
			height_reg = FRAME_DIM_BITS'(FRAME_HEIGHT_RST);
			no_depth = NO_DEPTH_RST;
			threshold = SIMILAR_THR_RST;
			min_similar = MIN_SIMILAR_RST;
			restart_frame();
			filtered_q.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_FRAME_WIDTH: begin
						width_reg = cfg_wdata[FRAME_DIM_BITS-1:0];
						restart_frame();
					end
					REG_FRAME_HEIGHT: begin
						height_reg = cfg_wdata[FRAME_DIM_BITS-1:0];
						restart_frame();
					end
					REG_NO_DEPTH: no_depth = cfg_wdata;
					REG_SIMILAR_THR: threshold = cfg_wdata;
					REG_MIN_SIMILAR: min_similar = cfg_wdata[MIN_SIM_BITS-1:0];
					default: ;
				endcase
			end

			if (px_valid && px_ready) begin
				if (px_item.func == FUNC_PIXEL) begin
					store(px_item.pixel_depth);
					in_col++;
					if (in_col >= active_width()) begin
						in_col = 0;
						in_row = (in_row + 1 >= active_height()) ? 0 : in_row + 1;
					end
					backlog++;
					if (backlog >= active_width() + 2) retire_center();
				end else if (in_row == 0 && in_col == 0 && backlog != 0) begin
					// filler slot, never used as a neighbor
					store(no_depth);
					retire_center();
				end
			end

			if (res_valid && res_ready) begin
				if (filtered_q.size() == 0) begin
					$error("unexpected result: filtered_depth %0d", res_item.filtered_depth);
					fail_count++;
				end else begin
					want = filtered_q.pop_front();
					results_seen++;
					if (res_item.filtered_depth !== want.filtered_depth) begin
						$error("filtered_depth: expected %0d, got %0d",
							want.filtered_depth, res_item.filtered_depth);
						fail_count++;
					end
					if (res_item.was_removed !== want.was_removed) begin
						$error("was_removed: expected %0d, got %0d",
							want.was_removed, res_item.was_removed);
						fail_count++;
					end
					if (res_item.frame_last !== want.frame_last) begin
						$error("frame_last: expected %0d, got %0d",
							want.frame_last, res_item.frame_last);
						fail_count++;
					end
				end
			end
		end
		results_due = filtered_q.size();
	end

endmodule

// ===== tb/depth_speckle_filter_test.sv =====
// top of the depth speckle filter testbench: clock, reset, register writes,
// pixel and drain requests with random gaps, result backpressure, verdict
// depends on dsf_pkg, depth_speckle_filter and depth_speckle_filter_checker
`timescale 1ns / 100ps

module depth_speckle_filter_test;
	import dsf_pkg::*;

	localparam int MAX_SIDE = 2048;
	// random requests to send, stray drains inside a frame not counted
	localparam int RANDOM_ITEMS = 1700;
	// cycles to let the five-stage pipeline empty after the last result
	localparam int SETTLE_CYCLES = 24;
	localparam int RUN_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n;

	logic px_valid;
	logic px_ready;
	px_item_t px_item;
	logic res_valid;
	logic res_ready;
	res_item_t res_item;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	int fail_count;
	int results_due;
	int results_seen;

	// stimulus bookkeeping
	int unsigned cycle_count = 0;
	int unsigned sent = 0;
	int unsigned stray_drains = 0;
	int unsigned settings = 0;
	int unsigned eff_w, eff_h;
	depth_t nd_now, thr_now;
	int unsigned field_base, field_span;
	// when set, neither side inserts idle cycles
	logic calm;

	depth_speckle_filter #(
		.MAX_WIDTH(MAX_SIDE),
		.MAX_HEIGHT(MAX_SIDE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.px_valid(px_valid),
		.px_ready(px_ready),
		.px_item(px_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	depth_speckle_filter_checker #(
		.MAX_WIDTH(MAX_SIDE),
		.MAX_HEIGHT(MAX_SIDE)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.px_valid(px_valid),
		.px_ready(px_ready),
		.px_item(px_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.results_due(results_due),
		.results_seen(results_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs or a result never shows up
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$error("cycle limit reached with %0d results still due", results_due);
			$display("Test completed with failures");
			$finish;
		end
	end

	// switch between stretches with random idling and stretches at full rate
	initial begin
		calm = 1'b0;
		forever begin
			repeat ($urandom_range(40, 400)) @(negedge clk);
			calm <= ($urandom_range(0, 3) == 0);
		end
	end

	// result side: random stall before each result, ready stays up while waiting
	initial begin : result_sink
		int unsigned hold;
		res_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 5);
			if (hold != 0) begin
				res_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// one request: optional gap, then valid held with a stable payload until taken
	task automatic send(input func_t f, input depth_t d);
		int unsigned gap;
		px_item_t req;
		gap = calm ? 0 : $urandom_range(0, 5);
		req.func = f;
		req.pixel_depth = d;
		if (gap != 0) begin
			px_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		px_valid <= 1'b1;
		px_item <= req;
		@(posedge clk);
		while (!px_ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// wait until every predicted result is out, then let the pipeline empty
	task automatic quiesce();
		px_valid <= 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// new filter setting, written only once the block is idle
	task automatic set_filter(input logic [FRAME_DIM_BITS-1:0] w,
			input logic [FRAME_DIM_BITS-1:0] h, input depth_t nd, input depth_t thr,
			input logic [MIN_SIM_BITS-1:0] ms);
		quiesce();
		cfg_write(REG_FRAME_WIDTH, CFG_DATA_BITS'(w));
		cfg_write(REG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
		cfg_write(REG_NO_DEPTH, nd);
		cfg_write(REG_SIMILAR_THR, thr);
		cfg_write(REG_MIN_SIMILAR, CFG_DATA_BITS'(ms));
		eff_w = (w < MIN_WIDTH) ? MIN_WIDTH : (w > MAX_SIDE) ? MAX_SIDE : w;
		eff_h = (h < MIN_HEIGHT) ? MIN_HEIGHT : (h > MAX_SIDE) ? MAX_SIDE : h;
		nd_now = nd;
		thr_now = thr;
		settings++;
	endtask

	// depths mostly clustered around a base so the neighbor votes land on
	// both sides of min_similar, with invalid pixels and outliers mixed in
	function automatic depth_t pick_depth();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 12) return nd_now;
		if (roll < 18) return depth_t'($urandom);
		if (roll < 20) return roll[0] ? 16'hFFFF : 16'h0000;
		return depth_t'(field_base + $urandom_range(0, field_span));
	endfunction

	// a run of pixel requests with a few stray drains mid-frame, then drains
	task automatic run_frame(input int unsigned pixels, input int unsigned drains);
		field_base = $urandom_range(0, 65535);
		field_span = (thr_now > 16'd20000) ? 65535 : 2 * thr_now + 1;
		for (int unsigned i = 0; i < pixels; i++) begin
			if ($urandom_range(0, 24) == 0) begin
				send(FUNC_DRAIN, depth_t'($urandom));
				stray_drains++;
			end
			send(FUNC_PIXEL, pick_depth());
		end
		for (int unsigned i = 0; i < drains; i++) send(FUNC_DRAIN, depth_t'($urandom));
	endtask

	initial begin : stimulus
		int unsigned first_count, frames, pixels, drains, roll;
		logic [FRAME_DIM_BITS-1:0] w_pick, h_pick;
		depth_t nd_pick, thr_pick;
		logic [MIN_SIM_BITS-1:0] ms_pick;

		arst_n = 1'b0;
		px_valid = 1'b0;
		px_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		eff_w = FRAME_WIDTH_RST;
		eff_h = FRAME_HEIGHT_RST;
		nd_now = NO_DEPTH_RST;
		thr_now = SIMILAR_THR_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// a few pixels under the reset setting, dropped by the next size write
		send(FUNC_PIXEL, 16'd100);
		send(FUNC_PIXEL, 16'd150);
		send(FUNC_PIXEL, 16'd400);

		// undersized frame registers act as 3x2; min_similar above 8 removes
		// every tested valid pixel, an invalid center passes untouched
		set_filter(12'd0, 12'd1, 16'd0, 16'd0, 4'd9);
		send(FUNC_DRAIN, 16'hFFFF);
		send(FUNC_PIXEL, 16'hFFFF);
		send(FUNC_PIXEL, 16'h0000);
		send(FUNC_PIXEL, 16'hFFFF);
		send(FUNC_DRAIN, 16'h0000);
		send(FUNC_PIXEL, 16'hFFFF);
		send(FUNC_PIXEL, 16'hFFFF);
		send(FUNC_PIXEL, 16'hFFFF);
		repeat (5) send(FUNC_DRAIN, 16'h5A5A);

		// all-ones invalid code, widest threshold; edge row center needs four
		// of its five neighbors, the invalid one never counts
		set_filter(12'd3, 12'd2, 16'hFFFF, 16'hFFFF, 4'd4);
		send(FUNC_PIXEL, 16'h0000);
		send(FUNC_PIXEL, 16'h0001);
		send(FUNC_PIXEL, 16'h0000);
		send(FUNC_PIXEL, 16'h0000);
		send(FUNC_PIXEL, 16'hFFFF);
		send(FUNC_PIXEL, 16'h0000);
		repeat (4) send(FUNC_DRAIN, 16'h0000);

		// random settings, mostly whole frames with random content
		first_count = sent - stray_drains;
		while (sent - stray_drains - first_count < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 19);
			if (roll == 0) w_pick = FRAME_DIM_BITS'($urandom_range(0, 2));
			else if (roll < 3) w_pick = FRAME_DIM_BITS'($urandom_range(13, 48));
			else w_pick = FRAME_DIM_BITS'($urandom_range(3, 12));
			if (w_pick > 12) h_pick = FRAME_DIM_BITS'($urandom_range(2, 3));
			else if ($urandom_range(0, 9) == 0) h_pick = FRAME_DIM_BITS'($urandom_range(0, 1));
			else h_pick = FRAME_DIM_BITS'($urandom_range(2, 6));

			roll = $urandom_range(0, 9);
			nd_pick = (roll < 6) ? 16'h0000 : (roll < 8) ? 16'hFFFF : depth_t'($urandom);
			case ($urandom_range(0, 7))
				0: thr_pick = 16'd0;
				1: thr_pick = 16'hFFFF;
				2: thr_pick = 16'd90;
				3: thr_pick = 16'd200;
				4: thr_pick = 16'd4000;
				7: thr_pick = depth_t'($urandom);
				default: thr_pick = depth_t'($urandom_range(0, 400));
			endcase
			ms_pick = ($urandom_range(0, 9) < 8) ? MIN_SIM_BITS'($urandom_range(0, 8))
				: MIN_SIM_BITS'($urandom_range(9, 15));

			set_filter(w_pick, h_pick, nd_pick, thr_pick, ms_pick);

			frames = $urandom_range(1, 3);
			for (int unsigned f = 1; f <= frames; f++) begin
				pixels = eff_w * eff_h;
				roll = $urandom_range(0, 9);
				if (f < frames) begin
					// next frame may push the tail out by itself
					if (roll < 4) drains = 0;
					else if (roll < 6) drains = $urandom_range(1, eff_w);
					else drains = eff_w + 1 + $urandom_range(0, 2);
				end else if (roll < 7) begin
					drains = eff_w + 1 + $urandom_range(0, 2);
				end else if (roll < 9) begin
					// leftover pixels get dropped by the next size write
					drains = $urandom_range(0, eff_w);
				end else begin
					// cut off mid-frame, drains here are ignored
					pixels = $urandom_range(1, pixels - 1);
					drains = $urandom_range(0, 2);
				end
				run_frame(pixels, drains);
			end
		end

		// widest frame: register above the limit clamps to the full line length;
		// only a short start of the line is sent, dropped by the next size write
		set_filter(12'hFFF, 12'd2, depth_t'($urandom), 16'd4000, 4'd3);
		run_frame(48, 1);

		// tallest frame: height clamps to the limit, width below 3 acts as 3;
		// only part of the frame is sent
		set_filter(12'd2, 12'hFFF, 16'd0, 16'd200, 4'd2);
		run_frame(40, 1);

		quiesce();
		$display("%0d requests over %0d filter settings, %0d results compared",
			sent, settings, results_seen);
		$display("frames from 3x2 up to 48 pixels wide, clamped sizes, all five registers swept");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
